// ===== hw/rtl/bfrd_pkg.sv =====
// Shared types and constants for the bulk frame and reply deframer.
package bfrd_pkg;

   localparam int LINE_BYTES = 64;
   localparam int LCNT_W = $clog2(LINE_BYTES + 1);

   localparam logic [7:0] CH_ESC = 8'h1b;
   localparam logic [7:0] CH_Z   = 8'h5a;
   localparam logic [7:0] CH_O   = 8'h4f;
   localparam logic [7:0] CH_F   = 8'h46;
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_1   = 8'h31;
   localparam logic [7:0] CH_8   = 8'h38;
   localparam logic [7:0] CH_9   = 8'h39;
   localparam logic [7:0] CH_LA  = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_DATA    = 3'd1,
      KIND_SEND_OK = 3'd2,
      KIND_SEND_FAIL = 3'd3,
      KIND_NUMERIC = 3'd4,
      KIND_UNKNOWN = 3'd5,
      KIND_MALFORMED = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      MODE_LINE = 3'd0,
      MODE_ESC  = 3'd1,
      MODE_ESCZ = 3'd2,
      MODE_LEN0 = 3'd3,
      MODE_LEN1 = 3'd4,
      MODE_LEN2 = 3'd5,
      MODE_LEN3 = 3'd6,
      MODE_BULK = 3'd7
   } mode_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  channel;
      logic [7:0]  data_byte;
      logic [13:0] frame_length;
      logic        last_of_frame;
      logic [4:0]  reply_code;
      logic [6:0]  arg_length;
      logic [3:0]  arg_channel;
      logic        arg_channel_valid;
      logic [6:0]  line_length;
   } rsp_type;

   // Line-end event handed from the front to the back.
   typedef struct packed {
      logic [LCNT_W-1:0] len;
      logic [7:0]        h0;
      logic [7:0]        h1;
      logic [7:0]        h2;
      logic [7:0]        h3;
   } line_type;

   // Queue entry: either a finished result or a line to classify.
   typedef struct packed {
      logic     is_line;
      rsp_type  rsp;
      line_type line;
   } work_type;

   function automatic logic [4:0] chan_digit(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
         t = c - CH_0;
         return {1'b1, t[3:0]};
      end
      if (c >= CH_LA && c <= CH_LF_HEX) begin
         t = c - CH_LA + 8'd10;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic logic [6:0] sat127(input logic [LCNT_W-1:0] v);
      if (LCNT_W > 7 && v > LCNT_W'(127)) return 7'd127;
      return 7'(v);
   endfunction

endpackage

// ===== hw/rtl/bfrd_if.sv =====
// Valid/ready channel interfaces for the deframer.
interface bfrd_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface bfrd_rsp_if (input logic clock);
   logic                 valid;
   logic                 ready;
   bfrd_pkg::rsp_type    rsp;
   modport source (output valid, output rsp, input ready);
   modport sink (input valid, input rsp, output ready);
endinterface

// ===== hw/rtl/bfrd_front.sv =====
// Front part: byte parser state, builds results and line-end records.
module bfrd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   output logic                in_ready,
   output logic                wr_en,
   output bfrd_pkg::work_type  wr_data,
   input  logic                q_full
);
   localparam int LW = bfrd_pkg::LCNT_W;

   bfrd_pkg::mode_type mode_ff, mode_in;
   logic [3:0]  chan_ff, chan_in;
   logic [13:0] rem_ff, rem_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [7:0]  head_ff [4];
   logic        head_we;
   logic [1:0]  head_idx;
   logic [4:0]  cd;
   logic [13:0] len_next;
   logic [13:0] rem_dec;
   logic        fire;

   assign in_ready = !q_full;
   assign fire = in_valid && in_ready;
   assign cd = bfrd_pkg::chan_digit(in_byte);
   assign len_next = 14'(rem_ff * 14'd10) + 14'(in_byte[3:0]);
   assign rem_dec = (rem_ff != 14'd0) ? rem_ff - 14'd1 : 14'd0;
   assign head_idx = cnt_ff[1:0];

   always_comb begin
      mode_in = mode_ff;
      chan_in = chan_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      head_we = 1'b0;
      wr_en   = 1'b0;
      wr_data = '0;
      wr_data.line.len = cnt_ff;
      wr_data.line.h0 = head_ff[0];
      wr_data.line.h1 = head_ff[1];
      wr_data.line.h2 = head_ff[2];
      wr_data.line.h3 = head_ff[3];
      if (fire) begin
         case (mode_ff)
            bfrd_pkg::MODE_LINE: begin
               if (in_byte == bfrd_pkg::CH_ESC) begin
                  mode_in = bfrd_pkg::MODE_ESC;
               end else if (in_byte == bfrd_pkg::CH_CR || in_byte == bfrd_pkg::CH_LF) begin
                  if (cnt_ff != '0) begin
                     wr_en = 1'b1;
                     wr_data.is_line = 1'b1;
                     cnt_in = '0;
                  end
               end else if (cnt_ff < LW'(bfrd_pkg::LINE_BYTES)) begin
                  head_we = (cnt_ff < LW'(4));
                  cnt_in = cnt_ff + LW'(1);
               end
            end
            bfrd_pkg::MODE_ESC: begin
               if (in_byte == bfrd_pkg::CH_Z) begin
                  mode_in = bfrd_pkg::MODE_ESCZ;
               end else begin
                  mode_in = bfrd_pkg::MODE_LINE;
                  wr_en = 1'b1;
                  if (in_byte == bfrd_pkg::CH_O) begin
                     wr_data.rsp.kind = bfrd_pkg::KIND_SEND_OK;
                  end else if (in_byte == bfrd_pkg::CH_F) begin
                     wr_data.rsp.kind = bfrd_pkg::KIND_SEND_FAIL;
                  end else begin
                     wr_data.rsp.kind = bfrd_pkg::KIND_MALFORMED;
                     wr_data.rsp.data_byte = in_byte;
                  end
               end
            end
            bfrd_pkg::MODE_ESCZ: begin
               if (!cd[4]) begin
                  mode_in = bfrd_pkg::MODE_LINE;
                  wr_en = 1'b1;
                  wr_data.rsp.kind = bfrd_pkg::KIND_MALFORMED;
                  wr_data.rsp.data_byte = in_byte;
               end else begin
                  chan_in = cd[3:0];
                  rem_in = '0;
                  mode_in = bfrd_pkg::MODE_LEN0;
               end
            end
            bfrd_pkg::MODE_BULK: begin
               wr_en = 1'b1;
               wr_data.rsp.kind = bfrd_pkg::KIND_DATA;
               wr_data.rsp.channel = chan_ff;
               wr_data.rsp.data_byte = in_byte;
               rem_in = rem_dec;
               if (rem_dec == 14'd0) begin
                  wr_data.rsp.last_of_frame = 1'b1;
                  mode_in = bfrd_pkg::MODE_LINE;
               end
            end
            default: begin
               if (in_byte < bfrd_pkg::CH_0 || in_byte > bfrd_pkg::CH_9) begin
                  mode_in = bfrd_pkg::MODE_LINE;
                  wr_en = 1'b1;
                  wr_data.rsp.kind = bfrd_pkg::KIND_MALFORMED;
                  wr_data.rsp.data_byte = in_byte;
               end else begin
                  rem_in = len_next;
                  if (mode_ff != bfrd_pkg::MODE_LEN3) begin
                     mode_in = bfrd_pkg::mode_type'(mode_ff + 3'd1);
                  end else begin
                     wr_en = 1'b1;
                     wr_data.rsp.kind = bfrd_pkg::KIND_HEADER;
                     wr_data.rsp.channel = chan_ff;
                     wr_data.rsp.frame_length = len_next;
                     if (len_next == 14'd0) begin
                        wr_data.rsp.last_of_frame = 1'b1;
                        mode_in = bfrd_pkg::MODE_LINE;
                     end else begin
                        mode_in = bfrd_pkg::MODE_BULK;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bfrd_pkg::MODE_LINE;
         chan_ff <= '0;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         chan_ff <= chan_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[head_idx] <= in_byte;
      end
   end
endmodule

// ===== hw/rtl/bfrd_queue.sv =====
// Short two-entry queue between front and back.
module bfrd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  bfrd_pkg::work_type wr_data,
   output logic               full,
   output logic               rd_valid,
   output bfrd_pkg::work_type rd_data,
   input  logic               rd_en
);
   bfrd_pkg::work_type mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] n_ff, n_in;

   assign full = (n_ff == 2'd2);
   assign rd_valid = (n_ff != 2'd0);
   assign rd_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ wr_en;
      rp_in = rp_ff ^ rd_en;
      n_in = n_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff  <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end
endmodule

// ===== hw/rtl/bfrd_back.sv =====
// Back part: classify line records and drive the registered result.
module bfrd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_valid,
   input  bfrd_pkg::work_type rd_data,
   output logic               rd_en,
   output logic               out_valid,
   output bfrd_pkg::rsp_type  out_rsp,
   input  logic               out_ready
);
   localparam int LW = bfrd_pkg::LCNT_W;

   logic valid_ff, valid_in;
   bfrd_pkg::rsp_type rsp_ff, line_rsp;
   logic [LW-1:0] len, arg;
   logic [7:0] sp, dg;
   logic [4:0] cd;
   logic two;

   assign out_valid = valid_ff;
   assign out_rsp = rsp_ff;
   assign rd_en = rd_valid && (!valid_ff || out_ready);
   assign valid_in = rd_en || (valid_ff && !out_ready);

   always_comb begin
      len = rd_data.line.len;
      two = (len >= LW'(2)) && rd_data.line.h0 == bfrd_pkg::CH_1
            && rd_data.line.h1 >= bfrd_pkg::CH_0 && rd_data.line.h1 <= bfrd_pkg::CH_8;
      sp = two ? rd_data.line.h2 : rd_data.line.h1;
      dg = two ? rd_data.line.h3 : rd_data.line.h2;
      cd = bfrd_pkg::chan_digit(dg);
      arg = len - (two ? LW'(2) : LW'(1));
      line_rsp = '0;
      line_rsp.line_length = bfrd_pkg::sat127(len);
      if (two || (rd_data.line.h0 >= bfrd_pkg::CH_0 && rd_data.line.h0 <= bfrd_pkg::CH_9)) begin
         line_rsp.kind = bfrd_pkg::KIND_NUMERIC;
         line_rsp.reply_code = two ? 5'(5'd10 + 5'(rd_data.line.h1[3:0]))
                                   : 5'(rd_data.line.h0[3:0]);
         line_rsp.arg_length = bfrd_pkg::sat127(arg);
         if (arg == LW'(2) && sp == bfrd_pkg::CH_SP && cd[4]) begin
            line_rsp.arg_channel = cd[3:0];
            line_rsp.arg_channel_valid = 1'b1;
         end
      end else begin
         line_rsp.kind = bfrd_pkg::KIND_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rsp_ff <= rd_data.is_line ? line_rsp : rd_data.rsp;
      end
   end
endmodule

// ===== hw/rtl/bulk_frame_and_reply_deframer.sv =====
// Top level of the bulk frame and reply deframer.
//
//   channel  | dir | payload
//   req      | in  | byte_in (8): one received link byte
//   rsp      | out | kind, channel, data_byte, frame_length, last_of_frame,
//            |     | reply_code, arg_length, arg_channel, arg_channel_valid,
//            |     | line_length
//
// One item per cycle sustained while the result sink keeps up; the front
// parser updates its state on each accepted byte. A result is registered
// first in the two-entry queue, then in the back's output register.
// Synchronous reset returns the parser to line mode and empties the queue.
// A stalled result sink fills the queue; req ready drops only when it is full.
module bulk_frame_and_reply_deframer (
   input logic clock,
   input logic reset,
   bfrd_req_if.sink   req,
   bfrd_rsp_if.source rsp
);
   logic               wr_en, q_full, rd_valid, rd_en;
   bfrd_pkg::work_type wr_data, rd_data;

   // Front: parse each byte, hand finished results or line records on.
   bfrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_byte  (req.byte_in),
      .in_ready (req.ready),
      .wr_en    (wr_en),
      .wr_data  (wr_data),
      .q_full   (q_full)
   );

   // Queue: decouple the parser from the result stall.
   bfrd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_data  (wr_data),
      .full     (q_full),
      .rd_valid (rd_valid),
      .rd_data  (rd_data),
      .rd_en    (rd_en)
   );

   // Back: classify lines and hold the result until taken.
   bfrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rd_valid  (rd_valid),
      .rd_data   (rd_data),
      .rd_en     (rd_en),
      .out_valid (rsp.valid),
      .out_rsp   (rsp.rsp),
      .out_ready (rsp.ready)
   );
endmodule
